// File: rtl/core/gcld_pkg.sv
// gcld_pkg: shared types and constants of the gray code light decoder
// no dependencies; used by gcld_update and gray_code_light_decoder_core
package gcld_pkg;

	localparam int PIXEL_COUNT = 1048576;
	localparam int PLANE_COUNT = 8;

	localparam int ADDR_W   = 20;
	localparam int SAMPLE_W = 8;
	localparam int THR_W    = 9;
	localparam int PIX_AW   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;
	localparam logic [SAMPLE_W-1:0] TOP_BIT    = 8'(1 << 7);

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_PLANE  = 2'd1,
		CMD_OUTPUT = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [PIX_AW-1:0] addr;
		logic [SAMPLE_W-1:0] data;
	} wr_t;

endpackage

// File: rtl/core/gcld_pixel_ram.sv
// gcld_pixel_ram: generic one-write one-read synchronous ram, registered read
// no package dependency
module gcld_pixel_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/gcld_update.sv
// gcld_update: per-pixel modify logic for weight, plane and output passes
// depends on gcld_pkg
module gcld_update
	import gcld_pkg::*;
(
	input  cmd_t                command,
	input  logic [2:0]          plane_index,
	input  logic                addr_ok,
	input  logic [PIX_AW-1:0]   addr,
	input  logic [SAMPLE_W-1:0] sample_first,
	input  logic [SAMPLE_W-1:0] sample_second,
	input  logic [SAMPLE_W-1:0] weight_rd,
	input  logic [SAMPLE_W-1:0] code_rd,
	input  logic [THR_W-1:0]    threshold,
	output logic [SAMPLE_W-1:0] result,
	output wr_t                 weight_wr,
	output wr_t                 code_wr
);

	logic                lit;
	logic [SAMPLE_W-1:0] diff;
	logic [3:0]          prev_sh;
	logic [2:0]          pos;
	logic                prev;
	logic [SAMPLE_W-1:0] new_code;
	logic                plane_ok;
	logic [SAMPLE_W-1:0] w_eff;
	logic [SAMPLE_W-1:0] c_eff;

	always_comb begin
		lit      = sample_first > sample_second;
		diff     = lit ? (sample_first - sample_second) : '0;
		plane_ok = {1'b0, plane_index} < 4'(PLANE_COUNT);
		prev_sh  = 4'd8 - {1'b0, plane_index};
		pos      = 3'd7 - plane_index;
		prev     = code_rd[prev_sh[2:0]];
		new_code = code_rd;
		new_code[pos] = lit ^ prev;
		if (plane_index == 3'd0) begin
			new_code = lit ? TOP_BIT : '0;
		end
		w_eff = addr_ok ? weight_rd : '0;
		c_eff = addr_ok ? code_rd : '0;

		result    = '0;
		weight_wr = '{en: 1'b0, addr: addr, data: diff};
		code_wr   = '{en: 1'b0, addr: addr, data: new_code};
		unique case (command)
			CMD_WEIGHT: begin
				result       = diff;
				weight_wr.en = addr_ok;
			end
			CMD_PLANE: begin
				result     = diff;
				code_wr.en = addr_ok && plane_ok;
			end
			CMD_OUTPUT: begin
				result = ({1'b0, w_eff} < threshold) ? '0 : (FULL_SCALE - c_eff);
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

// File: rtl/core/gray_code_light_decoder_core.sv
// Gray code structured light decoder: one pixel word per clock unless the
// output stalls. A word is accepted when in_valid is high and in_stall low;
// the rams are read at acceptance; as the stage advances, the result is
// registered and written back. Throughput is one word per cycle unless the
// output stalls, set by the one write and one read port of each pixel ram;
// a write to a pixel read in the same cycle is forwarded, so back-to-back
// words to one pixel are safe. The stores are not cleared: a weight or code
// read before it is written is undefined. The user must write shadow_threshold
// via cfg_valid/cfg_ready only while the block is idle; nothing enforces it.
module gray_code_light_decoder_core
	import gcld_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [THR_W-1:0]    shadow_threshold,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [2:0]          plane_index,
	input  logic [ADDR_W-1:0]   pixel_address,
	input  logic [SAMPLE_W-1:0] sample_first,
	input  logic [SAMPLE_W-1:0] sample_second,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SAMPLE_W-1:0] pixel_result
);

	logic [THR_W-1:0]    threshold_q;
	logic                advance;
	logic [PIX_AW-1:0]   rd_addr;
	logic                addr_ok_in;

	logic                valid_s1;
	cmd_t                command_s1;
	logic [2:0]          plane_s1;
	logic                addr_ok_s1;
	logic [PIX_AW-1:0]   addr_s1;
	logic [SAMPLE_W-1:0] first_s1;
	logic [SAMPLE_W-1:0] second_s1;

	logic [SAMPLE_W-1:0] weight_ram;
	logic [SAMPLE_W-1:0] code_ram;
	logic [SAMPLE_W-1:0] weight_rd;
	logic [SAMPLE_W-1:0] code_rd;
	wr_t                 weight_wr;
	wr_t                 code_wr;
	wr_t                 weight_fwd_q;
	wr_t                 code_fwd_q;
	logic                weight_we;
	logic                code_we;
	logic [SAMPLE_W-1:0] result;
	logic [SAMPLE_W-1:0] result_q;
	logic                out_valid_q;

	assign cfg_ready    = 1'b1;
	assign advance      = !(valid_s1 && out_valid_q && out_stall);
	assign in_stall     = !advance;
	assign out_valid    = out_valid_q;
	assign pixel_result = result_q;
	assign rd_addr      = PIX_AW'(pixel_address);
	assign addr_ok_in   = 32'(pixel_address) < 32'(PIXEL_COUNT);
	assign weight_we    = advance && valid_s1 && weight_wr.en;
	assign code_we      = advance && valid_s1 && code_wr.en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= shadow_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			weight_fwd_q <= '0;
			code_fwd_q   <= '0;
		end else begin
			if (advance) begin
				valid_s1     <= in_valid;
				weight_fwd_q <= '{en: weight_we, addr: weight_wr.addr, data: weight_wr.data};
				code_fwd_q   <= '{en: code_we, addr: code_wr.addr, data: code_wr.data};
			end
			if (advance && valid_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			command_s1           <= cmd_t'(command);
			plane_s1             <= plane_index;
			addr_ok_s1           <= addr_ok_in;
			addr_s1              <= rd_addr;
			first_s1             <= sample_first;
			second_s1            <= sample_second;
		end
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	// bypass the write that landed on the edge this word was read
	assign weight_rd = (weight_fwd_q.en && weight_fwd_q.addr == addr_s1) ?
		weight_fwd_q.data : weight_ram;
	assign code_rd = (code_fwd_q.en && code_fwd_q.addr == addr_s1) ?
		code_fwd_q.data : code_ram;

	gcld_pixel_ram #(
		.DEPTH(PIXEL_COUNT),
		.AW   (PIX_AW),
		.DW   (SAMPLE_W)
	) u_weight_ram (
		.clk  (clk),
		.we   (weight_we),
		.waddr(weight_wr.addr),
		.wdata(weight_wr.data),
		.re   (advance),
		.raddr(rd_addr),
		.rdata(weight_ram)
	);

	gcld_pixel_ram #(
		.DEPTH(PIXEL_COUNT),
		.AW   (PIX_AW),
		.DW   (SAMPLE_W)
	) u_code_ram (
		.clk  (clk),
		.we   (code_we),
		.waddr(code_wr.addr),
		.wdata(code_wr.data),
		.re   (advance),
		.raddr(rd_addr),
		.rdata(code_ram)
	);

	gcld_update u_update (
		.command      (command_s1),
		.plane_index  (plane_s1),
		.addr_ok      (addr_ok_s1),
		.addr         (addr_s1),
		.sample_first (first_s1),
		.sample_second(second_s1),
		.weight_rd    (weight_rd),
		.code_rd      (code_rd),
		.threshold    (threshold_q),
		.result       (result),
		.weight_wr    (weight_wr),
		.code_wr      (code_wr)
	);

endmodule

// File: tb/testbench.sv
// testbench: directed and random check of gray_code_light_decoder_core
// predicts every pixel word from its own weight and code stores; needs gcld_pkg
// and the core only
`timescale 1ns / 1ps

import gcld_pkg::*;

class light_decode_board;
	bit [7:0] weight_mem [bit [19:0]];
	bit [7:0] code_mem [bit [19:0]];
	bit [8:0] threshold;
	bit [7:0] expected_levels [$];
	int       mismatches;

	function void set_threshold(bit [8:0] value);
		threshold = value;
	endfunction

	function int pending();
		return expected_levels.size();
	endfunction

	function void note_pixel(cmd_t cmd, bit [2:0] plane, bit [19:0] addr,
		bit [7:0] first, bit [7:0] second);
		bit [7:0] level;
		bit [7:0] code;
		bit       lit;
		bit       prev;
		level = 8'd0;
		lit = first > second;
		case (cmd)
			CMD_WEIGHT: begin
				level = lit ? first - second : 8'd0;
				weight_mem[addr] = level;
			end
			CMD_PLANE: begin
				level = lit ? first - second : 8'd0;
				if (plane == 3'd0) begin
					code_mem[addr] = {lit, 7'd0};
				end else begin
					code = code_mem[addr];
					prev = code[4'd8 - plane];
					code[3'd7 - plane] = lit ^ prev;
					code_mem[addr] = code;
				end
			end
			CMD_OUTPUT: begin
				if ({1'b0, weight_mem[addr]} < threshold)
					level = 8'd0;
				else
					level = 8'd255 - code_mem[addr];
			end
			default: level = 8'd0;
		endcase
		expected_levels.push_back(level);
	endfunction

	function void check_level(bit [7:0] actual);
		bit [7:0] want;
		if (expected_levels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("pixel_result %0d arrived with no word outstanding", actual);
		end else begin
			want = expected_levels.pop_front();
			if (want != actual) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel_result mismatch: expected %0d, got %0d", want, actual);
			end
		end
	endfunction
endclass

module testbench;
	import gcld_pkg::*;

	localparam int IDLE_LIMIT = 500;
	localparam int PHASE_ITEMS = 68;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [THR_W-1:0]    shadow_threshold;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          command;
	logic [2:0]          plane_index;
	logic [ADDR_W-1:0]   pixel_address;
	logic [SAMPLE_W-1:0] sample_first;
	logic [SAMPLE_W-1:0] sample_second;
	logic                out_valid;
	logic                out_stall;
	logic [SAMPLE_W-1:0] pixel_result;

	light_decode_board board = new();
	bit                steady;
	int                idle_cycles;
	int                phase_items;
	bit                weight_set [bit [19:0]];
	bit                code_set [bit [19:0]];
	bit [19:0]         touched_pixels [$];

	gray_code_light_decoder_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.shadow_threshold (shadow_threshold),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.plane_index      (plane_index),
		.pixel_address    (pixel_address),
		.sample_first     (sample_first),
		.sample_second    (sample_second),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pixel_result     (pixel_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input cmd_t cmd, input logic [2:0] plane,
		input logic [19:0] addr, input logic [7:0] first, input logic [7:0] second);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		plane_index <= plane;
		pixel_address <= addr;
		sample_first <= first;
		sample_second <= second;
		do @(posedge clk); while (in_stall);
		board.note_pixel(cmd, plane, addr, first, second);
		if (cmd == CMD_WEIGHT)
			weight_set[addr] = 1'b1;
		if (cmd == CMD_PLANE && plane == 3'd0)
			code_set[addr] = 1'b1;
		phase_items++;
	endtask

	task automatic write_threshold(input logic [8:0] value);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		shadow_threshold <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_threshold(value);
		phase_items = 0;
	endtask

	task automatic run_sequence();
		logic [19:0] addr;
		int planes;
		if (touched_pixels.size() > 0 && $urandom_range(0, 1) == 0) begin
			addr = touched_pixels[$urandom_range(0, touched_pixels.size() - 1)];
		end else begin
			addr = 20'($urandom);
			touched_pixels.push_back(addr);
		end
		planes = $urandom_range(1, 8);
		send_pixel(CMD_WEIGHT, 3'($urandom), addr, pick_sample(), pick_sample());
		for (int p = 0; p < planes; p++)
			send_pixel(CMD_PLANE, 3'(p), addr, pick_sample(), pick_sample());
		send_pixel(CMD_OUTPUT, 3'($urandom), addr, pick_sample(), pick_sample());
	endtask

	task automatic send_noise();
		logic [19:0] addr;
		cmd_t        cmd;
		logic [2:0]  plane;
		if (touched_pixels.size() > 0 && $urandom_range(0, 3) != 0)
			addr = touched_pixels[$urandom_range(0, touched_pixels.size() - 1)];
		else
			addr = 20'($urandom);
		cmd = cmd_t'($urandom_range(0, 3));
		plane = 3'($urandom);
		// never read a store entry that was not written
		if (cmd == CMD_OUTPUT && !(weight_set.exists(addr) && code_set.exists(addr)))
			cmd = CMD_WEIGHT;
		if (cmd == CMD_PLANE && plane != 3'd0 && !code_set.exists(addr))
			plane = 3'd0;
		send_pixel(cmd, plane, addr, pick_sample(), pick_sample());
	endtask

	initial begin
		logic [8:0] phase_thresholds [6];
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		shadow_threshold <= '0;
		in_valid <= 1'b0;
		command <= CMD_NONE;
		plane_index <= '0;
		pixel_address <= '0;
		sample_first <= '0;
		sample_second <= '0;
		steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_threshold(9'd0);
		send_pixel(CMD_WEIGHT, 3'd0, 20'h00000, 8'd255, 8'd0);
		send_pixel(CMD_WEIGHT, 3'd7, 20'hFFFFF, 8'd0, 8'd255);
		send_pixel(CMD_WEIGHT, 3'd5, 20'hAAAAA, 8'd100, 8'd100);
		send_pixel(CMD_PLANE, 3'd0, 20'h00000, 8'd200, 8'd10);
		send_pixel(CMD_PLANE, 3'd0, 20'hFFFFF, 8'd0, 8'd255);
		send_pixel(CMD_PLANE, 3'd0, 20'hAAAAA, 8'd7, 8'd7);
		send_pixel(CMD_PLANE, 3'd1, 20'h00000, 8'd10, 8'd200);
		send_pixel(CMD_PLANE, 3'd2, 20'h00000, 8'd255, 8'd0);
		send_pixel(CMD_PLANE, 3'd3, 20'h00000, 8'd0, 8'd0);
		send_pixel(CMD_PLANE, 3'd4, 20'h00000, 8'd90, 8'd91);
		send_pixel(CMD_PLANE, 3'd5, 20'h00000, 8'd91, 8'd90);
		send_pixel(CMD_PLANE, 3'd6, 20'h00000, 8'd255, 8'd254);
		send_pixel(CMD_PLANE, 3'd7, 20'h00000, 8'd0, 8'd255);
		send_pixel(CMD_PLANE, 3'd1, 20'hFFFFF, 8'd255, 8'd1);
		send_pixel(CMD_OUTPUT, 3'd0, 20'h00000, 8'd0, 8'd0);
		send_pixel(CMD_OUTPUT, 3'd7, 20'hFFFFF, 8'd255, 8'd255);
		send_pixel(CMD_OUTPUT, 3'd3, 20'hAAAAA, 8'd1, 8'd2);
		send_pixel(CMD_NONE, 3'd7, 20'hAAAAA, 8'd255, 8'd255);
		// plane zero replaces the whole code
		send_pixel(CMD_PLANE, 3'd0, 20'h00000, 8'd5, 8'd6);
		send_pixel(CMD_OUTPUT, 3'd0, 20'h00000, 8'd0, 8'd0);
		write_threshold(9'd256);
		send_pixel(CMD_OUTPUT, 3'd0, 20'h00000, 8'd0, 8'd0);
		write_threshold(9'd255);
		send_pixel(CMD_OUTPUT, 3'd0, 20'h00000, 8'd0, 8'd0);
		write_threshold(9'd1);
		send_pixel(CMD_OUTPUT, 3'd0, 20'hFFFFF, 8'd0, 8'd0);
		touched_pixels.push_back(20'h00000);
		touched_pixels.push_back(20'hFFFFF);
		touched_pixels.push_back(20'hAAAAA);

		phase_thresholds = '{9'd256, 9'd0, 9'($urandom), 9'd1, 9'd255, 9'($urandom)};
		foreach (phase_thresholds[i]) begin
			write_threshold(phase_thresholds[i]);
			while (phase_items < PHASE_ITEMS) begin
				steady = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) < 7)
					run_sequence();
				else
					send_noise();
			end
		end

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// result side: random stall before each word
	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(arst_n && out_valid && !out_stall));
			board.check_level(pixel_result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

endmodule
